>>> src/hsvrgb_pkg.sv
// Shared constants, widths and a helper function for the HSV to RGB converter.
package hsvrgb_pkg;

    localparam int unsigned HUE_W = 9;
    localparam int unsigned PCT_W = 7;
    localparam int unsigned CH_W  = 8;
    localparam int unsigned PART_W = 14;
    localparam int unsigned RAMP_W = 10;
    localparam int unsigned PROD_W = PART_W + RAMP_W;

    localparam logic [PCT_W-1:0]  PCT_SCALE  = 7'd100;
    localparam logic [RAMP_W-1:0] RAMP_SCALE = 10'd1000;
    localparam logic [HUE_W-1:0]  SECTOR_DEG = 9'd60;
    localparam logic [HUE_W-1:0]  FULL_TURN  = 9'd360;
    localparam logic [CH_W-1:0]   OUT_MAX    = 8'd255;

    // Floor reciprocals: q = (x * RECIP) >> SHIFT is exact or one low.
    localparam int unsigned RAMP_SHIFT = 24;
    localparam logic [14:0] RAMP_RECIP = 15'd16777;
    localparam int unsigned CH_SHIFT = 22;
    localparam logic [8:0]  CH_RECIP = 9'd419;
    localparam logic [PART_W-1:0] CH_DIV = 14'd10000;

    // Exact floor of r * 1000 / 60 for r in 0..59 as (r * RECIP) >> SHIFT.
    localparam int unsigned SECTOR_SHIFT = 13;
    localparam logic [17:0] SECTOR_RECIP = 18'd136550;

    localparam int unsigned STAGES = 8;

    // Rising ramp within one sector: floor(r * 1000 / 60) for r in 0..59.
    function automatic logic [RAMP_W-1:0] ramp_of(input logic [5:0] r);
        logic [23:0] prod;
        begin
            prod = 24'(r) * 24'(SECTOR_RECIP);
            ramp_of = RAMP_W'(prod >> SECTOR_SHIFT);
        end
    endfunction

endpackage

>>> src/hsvrgb_scale.sv
// Three-stage scaling of one channel: (part + white) * 255 / 10000, truncated.
module hsvrgb_scale (
    input  logic                          clk,
    input  logic [2:0]                    en,
    input  logic [hsvrgb_pkg::PART_W-1:0] part,
    input  logic [hsvrgb_pkg::PART_W-1:0] white,
    output logic [hsvrgb_pkg::CH_W-1:0]   chan
);
    import hsvrgb_pkg::*;

    localparam int unsigned T_W = PART_W + CH_W;

    logic [T_W-1:0]      t_reg;
    logic [T_W-1:0]      t_next;
    logic [T_W-1:0]      t2_reg;
    logic [CH_W-1:0]     q_reg;
    logic [CH_W-1:0]     q_next;
    logic [CH_W-1:0]     chan_reg;
    logic [CH_W-1:0]     chan_next;
    logic [T_W+8:0]      est;
    logic [T_W-1:0]      rem;

    always_comb
    begin
        t_next = T_W'(part + white) * T_W'(OUT_MAX);
        est = (T_W+9)'(t_reg) * (T_W+9)'(CH_RECIP);
        q_next = est[CH_SHIFT+CH_W-1:CH_SHIFT];
        rem = t2_reg - T_W'(q_reg) * T_W'(CH_DIV);
        chan_next = (rem >= T_W'(CH_DIV)) ? q_reg + 8'd1 : q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t_reg <= t_next;
        end
        if (en[1])
        begin
            t2_reg <= t_reg;
            q_reg <= q_next;
        end
        if (en[2])
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

>>> src/hsv_to_rgb_fixed.sv
// Top level of the pipelined HSV to RGB converter with valid/ready channels.
//
// Converts hue (degrees), saturation and brightness (percent) into 8-bit red,
// green and blue. One item is accepted every clock cycle while the pipeline is
// not stalled by back-pressure. The pipeline depth is set by the two constant
// divisions (by 1000 for the hue ramp and by 10000 for the channel scaling),
// each done as a reciprocal multiply, a registered correction and a compare.
// Each stage stalls only when it is full and the stage after it cannot take
// its item, so bubbles close up under back-pressure. A hue of 360 or more is
// wrapped by subtracting 360 once, and saturation or brightness above 100 is
// taken as 100.
module hsv_to_rgb_fixed (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0] hue,
    input  logic [hsvrgb_pkg::PCT_W-1:0] saturation,
    input  logic [hsvrgb_pkg::PCT_W-1:0] brightness,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hsvrgb_pkg::CH_W-1:0]  red,
    output logic [hsvrgb_pkg::CH_W-1:0]  green,
    output logic [hsvrgb_pkg::CH_W-1:0]  blue
);
    import hsvrgb_pkg::*;

    typedef enum logic [2:0] {
        SEC_R_G,
        SEC_G_R,
        SEC_G_B,
        SEC_B_G,
        SEC_B_R,
        SEC_R_B
    } sector_t;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] adv;

    logic [HUE_W-1:0]  h_wrap;
    logic [PCT_W-1:0]  s_clamp;
    logic [PCT_W-1:0]  v_clamp;
    sector_t           sec_next;
    logic [HUE_W-1:0]  sec_base;
    logic [5:0]        r_off;
    logic [RAMP_W-1:0] ramp_raw;
    logic [RAMP_W-1:0] ramp_next;

    sector_t           sec0_reg;
    logic [RAMP_W-1:0] ramp0_reg;
    logic [PCT_W-1:0]  s0_reg;
    logic [PCT_W-1:0]  v0_reg;

    sector_t           sec1_reg;
    logic [RAMP_W-1:0] ramp1_reg;
    logic [PART_W-1:0] chroma1_reg;
    logic [PART_W-1:0] white1_reg;

    sector_t           sec2_reg;
    logic [PART_W-1:0] chroma2_reg;
    logic [PART_W-1:0] white2_reg;
    logic [PROD_W-1:0] x2_reg;

    sector_t           sec3_reg;
    logic [PART_W-1:0] chroma3_reg;
    logic [PART_W-1:0] white3_reg;
    logic [PROD_W-1:0] x3_reg;
    logic [PART_W-1:0] q3_reg;

    sector_t           sec4_reg;
    logic [PART_W-1:0] chroma4_reg;
    logic [PART_W-1:0] white4_reg;
    logic [PART_W-1:0] second4_reg;

    logic [PROD_W+14:0] est;
    logic [PART_W-1:0]  q_next;
    logic [PROD_W-1:0]  rem;
    logic [PART_W-1:0]  second_next;
    logic [PART_W-1:0]  part_r;
    logic [PART_W-1:0]  part_g;
    logic [PART_W-1:0]  part_b;

    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        h_wrap = (hue >= FULL_TURN) ? hue - FULL_TURN : hue;
        s_clamp = (saturation > PCT_SCALE) ? PCT_SCALE : saturation;
        v_clamp = (brightness > PCT_SCALE) ? PCT_SCALE : brightness;
        if (h_wrap < 9'd60)
        begin
            sec_next = SEC_R_G;
            sec_base = 9'd0;
        end
        else if (h_wrap < 9'd120)
        begin
            sec_next = SEC_G_R;
            sec_base = 9'd60;
        end
        else if (h_wrap < 9'd180)
        begin
            sec_next = SEC_G_B;
            sec_base = 9'd120;
        end
        else if (h_wrap < 9'd240)
        begin
            sec_next = SEC_B_G;
            sec_base = 9'd180;
        end
        else if (h_wrap < 9'd300)
        begin
            sec_next = SEC_B_R;
            sec_base = 9'd240;
        end
        else
        begin
            sec_next = SEC_R_B;
            sec_base = 9'd300;
        end
        r_off = 6'(h_wrap - sec_base);
        ramp_raw = ramp_of(r_off);
        ramp_next = sec_next[0] ? RAMP_SCALE - ramp_raw : ramp_raw;
    end

    always_comb
    begin
        est = (PROD_W+15)'(x2_reg) * (PROD_W+15)'(RAMP_RECIP);
        q_next = est[RAMP_SHIFT+PART_W-1:RAMP_SHIFT];
        rem = x3_reg - PROD_W'(q3_reg) * PROD_W'(RAMP_SCALE);
        second_next = (rem >= PROD_W'(RAMP_SCALE)) ? q3_reg + 14'd1 : q3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sec0_reg <= sec_next;
            ramp0_reg <= ramp_next;
            s0_reg <= s_clamp;
            v0_reg <= v_clamp;
        end
        if (adv[1])
        begin
            sec1_reg <= sec0_reg;
            ramp1_reg <= ramp0_reg;
            chroma1_reg <= PART_W'(v0_reg) * PART_W'(s0_reg);
            white1_reg <= PART_W'(v0_reg) * PART_W'(PCT_SCALE - s0_reg);
        end
        if (adv[2])
        begin
            sec2_reg <= sec1_reg;
            chroma2_reg <= chroma1_reg;
            white2_reg <= white1_reg;
            x2_reg <= PROD_W'(chroma1_reg) * PROD_W'(ramp1_reg);
        end
        if (adv[3])
        begin
            sec3_reg <= sec2_reg;
            chroma3_reg <= chroma2_reg;
            white3_reg <= white2_reg;
            x3_reg <= x2_reg;
            q3_reg <= q_next;
        end
        if (adv[4])
        begin
            sec4_reg <= sec3_reg;
            chroma4_reg <= chroma3_reg;
            white4_reg <= white3_reg;
            second4_reg <= second_next;
        end
    end

    always_comb
    begin
        case (sec4_reg)
            SEC_R_G:
            begin
                part_r = chroma4_reg;
                part_g = second4_reg;
                part_b = '0;
            end
            SEC_G_R:
            begin
                part_r = second4_reg;
                part_g = chroma4_reg;
                part_b = '0;
            end
            SEC_G_B:
            begin
                part_r = '0;
                part_g = chroma4_reg;
                part_b = second4_reg;
            end
            SEC_B_G:
            begin
                part_r = '0;
                part_g = second4_reg;
                part_b = chroma4_reg;
            end
            SEC_B_R:
            begin
                part_r = second4_reg;
                part_g = '0;
                part_b = chroma4_reg;
            end
            default:
            begin
                part_r = chroma4_reg;
                part_g = '0;
                part_b = second4_reg;
            end
        endcase
    end

    hsvrgb_scale u_scale_r (
        .clk   (clk),
        .en    (adv[7:5]),
        .part  (part_r),
        .white (white4_reg),
        .chan  (red)
    );

    hsvrgb_scale u_scale_g (
        .clk   (clk),
        .en    (adv[7:5]),
        .part  (part_g),
        .white (white4_reg),
        .chan  (green)
    );

    hsvrgb_scale u_scale_b (
        .clk   (clk),
        .en    (adv[7:5]),
        .part  (part_b),
        .white (white4_reg),
        .chan  (blue)
    );

    assign in_ready = adv[0];
    assign out_valid = vld_reg[STAGES-1];

endmodule
